// ===== hw/rtl/csr_adjacency_store_macros.svh =====
// Assertion macros shared by the adjacency store RTL.
`ifndef CSR_ADJACENCY_STORE_MACROS_SVH
`define CSR_ADJACENCY_STORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CAS_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition at one edge that implies another at the next edge.
`define CAS_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/csradj_pkg.sv =====
package csradj_pkg;

	localparam int MAX_NODES_DEF      = 1024;
	localparam int MAX_EDGE_SLOTS_DEF = 4096;

	localparam int OP_W     = 3;
	localparam int NODE_W   = 10;
	localparam int EIDX_W   = 12;
	localparam int STATUS_W = 3;
	localparam int DEG_W    = 13;
	localparam int NDONE_W  = 11;

	typedef enum logic [OP_W-1:0] {
		OP_RESTART = 3'd0,
		OP_ADD     = 3'd1,
		OP_CLOSE   = 3'd2,
		OP_DEGREE  = 3'd3,
		OP_EDGE    = 3'd4,
		OP_ADJ     = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NODE_FULL  = 3'd1,
		ST_EDGE_FULL  = 3'd2,
		ST_BAD_NODE   = 3'd3,
		ST_BAD_EDGE   = 3'd4,
		ST_BAD_TARGET = 3'd5
	} status_t;

endpackage

// ===== hw/rtl/csradj_ram.sv =====
module csradj_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/csr_adjacency_store.sv =====
// Compressed-sparse-row adjacency store. Requests are taken one at a time.
// Restart, add edge, close node, unused codes and every rejected request
// are answered straight from idle, so a stream of them runs at one per clock
// while the result side keeps up. A degree query or an edge target read
// goes through the lookup state for the synchronous memory read. An
// adjacency test walks the shorter of the two neighbor lists: the single
// read port of the edge memory walks that list one slot per cycle, and the
// walk stops early on a match. No clearing pass is needed after reset.
`include "csr_adjacency_store_macros.svh"

module csr_adjacency_store #(
	parameter int MAX_NODES      = csradj_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGE_SLOTS = csradj_pkg::MAX_EDGE_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [csradj_pkg::OP_W-1:0]     operation,
	input  logic [csradj_pkg::NODE_W-1:0]   first_node,
	input  logic [csradj_pkg::NODE_W-1:0]   second_node,
	input  logic [csradj_pkg::NODE_W-1:0]   target_node,
	input  logic [csradj_pkg::EIDX_W-1:0]   edge_index,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [csradj_pkg::STATUS_W-1:0] status,
	output logic [csradj_pkg::DEG_W-1:0]    neighbor_count,
	output logic [csradj_pkg::DEG_W-1:0]    first_edge,
	output logic [csradj_pkg::NODE_W-1:0]   edge_target,
	output logic                            adjacent,
	output logic [csradj_pkg::NDONE_W-1:0]  nodes_done,
	output logic [csradj_pkg::DEG_W-1:0]    edges_done
);

	import csradj_pkg::*;

	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int OAW = $clog2(MAX_NODES);
	localparam int EW  = $clog2(MAX_EDGE_SLOTS + 1);
	localparam int EAW = $clog2(MAX_EDGE_SLOTS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_PAIR = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     closed_q, closed_d;
	logic [EW-1:0]     filled_q, filled_d;
	logic [EW-1:0]     start_q, start_d;
	op_t               op_q, op_in;
	logic [NODE_W-1:0] v_q, u_q, key_q;
	logic [EW-1:0]     offv0_q, offv1_q, e_q, end_q;
	logic              pend_q;

	logic              rsp_valid_q;
	status_t           status_q;
	logic [DEG_W-1:0]  cnt_q, fedge_q, edone_q;
	logic [NODE_W-1:0] etgt_q;
	logic              adj_q;
	logic [NDONE_W-1:0] ndone_q;

	logic        req_fire, rsp_fire;
	logic [31:0] v_ext, u_ext, tgt_ext, ei_ext;
	logic        bad_v, bad_u, bad_tgt, bad_e, edge_full, node_full;
	status_t     imm_st;
	logic        imm_load, go_look, off_we, edge_we;

	logic [OAW-1:0]    ra;
	logic [2*EW-1:0]   off_rd;
	logic [EW-1:0]     off_a, off_b;
	logic [EAW-1:0]    edge_raddr;
	logic [NODE_W-1:0] edge_rd;

	logic [EW-1:0] deg_v, deg_u;
	logic          swap, more, hit, scan_done;

	logic              ld, ld_adj;
	status_t           ld_st;
	logic [DEG_W-1:0]  ld_cnt, ld_fe;
	logic [NODE_W-1:0] ld_tgt;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign rsp_fire  = rsp_valid_q && rsp_ready;
	assign op_in     = op_t'(operation);

	assign v_ext   = 32'(first_node);
	assign u_ext   = 32'(second_node);
	assign tgt_ext = 32'(target_node);
	assign ei_ext  = 32'(edge_index);

	assign bad_v     = v_ext >= 32'(closed_q);
	assign bad_u     = u_ext >= 32'(closed_q);
	assign bad_tgt   = tgt_ext >= 32'(MAX_NODES);
	assign bad_e     = ei_ext >= 32'(filled_q);
	assign edge_full = 32'(filled_q) >= 32'(MAX_EDGE_SLOTS);
	assign node_full = 32'(closed_q) >= 32'(MAX_NODES);

	always_comb begin
		closed_d = closed_q;
		filled_d = filled_q;
		start_d  = start_q;
		imm_st   = ST_OK;
		imm_load = 1'b0;
		go_look  = 1'b0;
		off_we   = 1'b0;
		edge_we  = 1'b0;
		if (req_fire) begin
			unique case (op_in)
				OP_RESTART: begin
					closed_d = '0;
					filled_d = '0;
					start_d  = '0;
					imm_load = 1'b1;
				end
				OP_ADD: begin
					imm_load = 1'b1;
					if (edge_full) begin
						imm_st = ST_EDGE_FULL;
					end else if (bad_tgt) begin
						imm_st = ST_BAD_TARGET;
					end else begin
						edge_we  = 1'b1;
						filled_d = filled_q + 1'b1;
					end
				end
				OP_CLOSE: begin
					imm_load = 1'b1;
					if (node_full) begin
						imm_st = ST_NODE_FULL;
					end else begin
						off_we   = 1'b1;
						closed_d = closed_q + 1'b1;
						start_d  = filled_q;
					end
				end
				OP_DEGREE: begin
					if (bad_v) begin
						imm_load = 1'b1;
						imm_st   = ST_BAD_NODE;
					end else begin
						go_look = 1'b1;
					end
				end
				OP_EDGE: begin
					if (bad_e) begin
						imm_load = 1'b1;
						imm_st   = ST_BAD_EDGE;
					end else begin
						go_look = 1'b1;
					end
				end
				OP_ADJ: begin
					if (bad_v || bad_u) begin
						imm_load = 1'b1;
						imm_st   = ST_BAD_NODE;
					end else begin
						go_look = 1'b1;
					end
				end
				default: begin
					imm_load = 1'b1;
				end
			endcase
		end
	end

	// Each entry holds both ends of a node's range, so one read gives the
	// first slot and the degree together.
	assign ra = (state_q == S_LOOK) ? OAW'(u_q) : OAW'(v_ext);

	csradj_ram #(
		.DEPTH (MAX_NODES),
		.WIDTH (2 * EW)
	) u_off (
		.clk   (clk),
		.we    (off_we),
		.waddr (OAW'(closed_q)),
		.wdata ({start_q, filled_q}),
		.raddr (ra),
		.rdata (off_rd)
	);

	assign off_a = off_rd[2*EW-1:EW];
	assign off_b = off_rd[EW-1:0];

	assign edge_raddr = (state_q == S_SCAN) ? EAW'(e_q) : EAW'(ei_ext);

	csradj_ram #(
		.DEPTH (MAX_EDGE_SLOTS),
		.WIDTH (NODE_W)
	) u_edge (
		.clk   (clk),
		.we    (edge_we),
		.waddr (EAW'(filled_q)),
		.wdata (target_node),
		.raddr (edge_raddr),
		.rdata (edge_rd)
	);

	assign deg_v     = offv1_q - offv0_q;
	assign deg_u     = off_b - off_a;
	assign swap      = deg_v > deg_u;
	assign more      = e_q < end_q;
	assign hit       = pend_q && (edge_rd == key_q);
	assign scan_done = hit || !more;

	always_comb begin
		state_d = state_q;
		ld      = imm_load;
		ld_st   = imm_st;
		ld_cnt  = '0;
		ld_fe   = '0;
		ld_tgt  = '0;
		ld_adj  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (go_look) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				case (op_q)
					OP_DEGREE: begin
						ld      = 1'b1;
						ld_cnt  = DEG_W'(off_b - off_a);
						ld_fe   = DEG_W'(off_a);
						state_d = S_IDLE;
					end
					OP_EDGE: begin
						ld      = 1'b1;
						ld_tgt  = edge_rd;
						state_d = S_IDLE;
					end
					default: begin
						state_d = S_PAIR;
					end
				endcase
			end
			S_PAIR: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_done) begin
					ld      = 1'b1;
					ld_adj  = hit;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			closed_q    <= '0;
			filled_q    <= '0;
			start_q     <= '0;
			rsp_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			closed_q <= closed_d;
			filled_q <= filled_d;
			start_q  <= start_d;
			if (ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_fire) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_PAIR) begin
				pend_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				pend_q <= more && !hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q <= op_in;
			v_q  <= first_node;
			u_q  <= second_node;
		end
		if (state_q == S_LOOK) begin
			offv0_q <= off_a;
			offv1_q <= off_b;
		end
		if (state_q == S_PAIR) begin
			e_q   <= swap ? off_a : offv0_q;
			end_q <= swap ? off_b : offv1_q;
			key_q <= swap ? v_q : u_q;
		end else if (state_q == S_SCAN && more) begin
			e_q <= e_q + 1'b1;
		end
		if (ld) begin
			status_q <= ld_st;
			cnt_q    <= ld_cnt;
			fedge_q  <= ld_fe;
			etgt_q   <= ld_tgt;
			adj_q    <= ld_adj;
			ndone_q  <= NDONE_W'(closed_d);
			edone_q  <= DEG_W'(filled_d);
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign neighbor_count = cnt_q;
	assign first_edge     = fedge_q;
	assign edge_target    = etgt_q;
	assign adjacent       = adj_q;
	assign nodes_done     = ndone_q;
	assign edges_done     = edone_q;

	`CAS_CHECK(a_filled_bound, 32'(filled_q) <= 32'(MAX_EDGE_SLOTS), "edge count past capacity")
	`CAS_CHECK(a_closed_bound, 32'(closed_q) <= 32'(MAX_NODES), "node count past capacity")
	`CAS_CHECK(a_slot_free_busy, (state_q != S_IDLE) |-> !rsp_valid_q, "result held in lookup")
	`CAS_NEXT(a_add_step, edge_we, filled_q == $past(filled_q) + 1'b1, "edge count did not advance")
	`CAS_CHECK(a_err_clean, (rsp_valid_q && status_q != ST_OK) |-> (!adj_q && cnt_q == '0), "error data")

endmodule
